### rtl/core/cfrl_pkg.sv
`timescale 1ns / 1ps

package cfrl_pkg;

  // Ring geometry
  localparam int LOG_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  // Fixed field widths
  localparam int WORD_W    = 32;
  localparam int CODE_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int STORED_W  = 17;

  // CRC-32, reflected
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CRC_XOR  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam int REC_BYTES = 20;
  localparam int BCNT_W    = $clog2(REC_BYTES);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_CRC   = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ADDR = 7'b0000010,
    ST_SLOT = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_LOAD = 7'b0010000,
    ST_CRC  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] ts;
    logic [WORD_W-1:0] css;
    logic [WORD_W-1:0] ca;
    logic [WORD_W-1:0] cb;
    logic [WORD_W-1:0] crc;
  } rec_t;

  // Advance the CRC by one byte, LSB first
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {WORD_W{c[0]}});
    end
    return c;
  endfunction

  // Records held for a given running total: min(total, LOG_DEPTH)
  function automatic logic [CNT_W-1:0] stored_of(input logic [WORD_W-1:0] total);
    logic [CNT_W-1:0] s;
    if (total < WORD_W'(LOG_DEPTH)) begin
      s = total[CNT_W-1:0];
    end else begin
      s = CNT_W'(LOG_DEPTH);
    end
    return s;
  endfunction

endpackage

### rtl/core/crc_checked_fault_ring_log.sv
`timescale 1ns / 1ps

// Circular fault log with a CRC-32 on each stored record.
// Input channel (in_valid/in_ready): in_operation selects append (store a fault
// record tagged with the next sequence number) or read (fetch the record at
// in_read_index counted from the oldest one held). Output channel
// (out_valid/out_ready): one result per input item carrying the status, the
// record fields on a good read, the running total and the number of records held.
// Throughput: one item at a time. A single byte-wide CRC unit runs over the 20
// packed record bytes, one byte per cycle. An append goes straight to the CRC pass;
// an in-range read first passes the slot arithmetic states (ADDR, SLOT), the
// registered memory read (RD) and the load (LOAD), then the CRC pass. A read whose
// index is out of range goes straight to the result state.
// The record store is a 1024-entry single-write, single-read memory; entries
// are never cleared and are only read once written.
// Reset clears the write pointer, the total and the control state; the log is
// empty afterwards and an input item can be taken in the first cycle.
// The result sits in an output register: a new item is taken while it waits,
// but that item does not finish, and does not change the log, until the
// pending result has been transferred.

module crc_checked_fault_ring_log (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [cfrl_pkg::WORD_W-1:0]       in_timestamp,
  input  logic [cfrl_pkg::CODE_W-1:0]       in_event_code,
  input  logic [cfrl_pkg::BYTE_W-1:0]       in_severity,
  input  logic [cfrl_pkg::BYTE_W-1:0]       in_source,
  input  logic [cfrl_pkg::WORD_W-1:0]       in_context_a,
  input  logic [cfrl_pkg::WORD_W-1:0]       in_context_b,
  input  logic [cfrl_pkg::INDEX_W-1:0]      in_read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cfrl_pkg::STATUS_W-1:0]     out_status,
  output logic [cfrl_pkg::WORD_W-1:0]       out_timestamp,
  output logic [cfrl_pkg::CODE_W-1:0]       out_event_code,
  output logic [cfrl_pkg::BYTE_W-1:0]       out_severity,
  output logic [cfrl_pkg::BYTE_W-1:0]       out_source,
  output logic [cfrl_pkg::WORD_W-1:0]       out_context_a,
  output logic [cfrl_pkg::WORD_W-1:0]       out_context_b,
  output logic [cfrl_pkg::WORD_W-1:0]       out_logged_total,
  output logic [cfrl_pkg::STORED_W-1:0]     out_stored_count
);

  localparam int SUM_W = cfrl_pkg::ADDR_W + 2;

  cfrl_pkg::state_t                  state_r, state_nxt;
  logic [cfrl_pkg::ADDR_W-1:0]       wp_r;
  logic [cfrl_pkg::WORD_W-1:0]       total_r;
  logic                              out_valid_r;

  logic                              op_r;
  logic                              range_r;
  logic [cfrl_pkg::CNT_W-1:0]        idx_r;
  logic [cfrl_pkg::CNT_W-1:0]        stored_r;
  logic [cfrl_pkg::ADDR_W-1:0]       oldest_r;
  logic [cfrl_pkg::ADDR_W-1:0]       slot_r;
  cfrl_pkg::rec_t                    rec_r;
  cfrl_pkg::rec_t                    mem_q_r;
  logic [cfrl_pkg::REC_BYTES*cfrl_pkg::BYTE_W-1:0] sh_r;
  logic [cfrl_pkg::WORD_W-1:0]       crc_r;
  logic [cfrl_pkg::BCNT_W-1:0]       bcnt_r;

  cfrl_pkg::rec_t                    mem [cfrl_pkg::LOG_DEPTH];

  logic [1:0]                        out_status_r;
  logic [cfrl_pkg::WORD_W-1:0]       out_ts_r, out_css_r, out_ca_r, out_cb_r;
  logic [cfrl_pkg::WORD_W-1:0]       out_total_r;
  logic [cfrl_pkg::STORED_W-1:0]     out_stored_r;

  logic                              in_xfer;
  logic                              fin_go;
  logic [cfrl_pkg::CNT_W-1:0]        stored_now;
  logic [SUM_W-1:0]                  oldest_sum;
  logic [SUM_W-1:0]                  slot_sum;
  logic [cfrl_pkg::WORD_W-1:0]       crc_final;
  logic [cfrl_pkg::WORD_W-1:0]       total_new;
  logic [cfrl_pkg::WORD_W-1:0]       seq_new;
  logic                              mem_we;
  cfrl_pkg::rec_t                    mem_wdata;

  assign in_ready   = (state_r == cfrl_pkg::ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign fin_go     = (state_r == cfrl_pkg::ST_FIN) && (!out_valid_r || out_ready);
  assign stored_now = cfrl_pkg::stored_of(total_r);
  assign seq_new    = total_r + 32'd1;
  assign crc_final  = crc_r ^ cfrl_pkg::CRC_XOR;
  assign total_new  = (op_r == cfrl_pkg::OP_APPEND) ? seq_new : total_r;

  // oldest = (wp + depth - stored) mod depth; slot = (oldest + idx) mod depth
  assign oldest_sum = SUM_W'(wp_r) + SUM_W'(cfrl_pkg::LOG_DEPTH) - SUM_W'(stored_r);
  assign slot_sum   = SUM_W'(oldest_r) + SUM_W'(idx_r);

  assign mem_we    = fin_go && (op_r == cfrl_pkg::OP_APPEND);
  always_comb begin
    mem_wdata     = rec_r;
    mem_wdata.crc = crc_final;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfrl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_operation == cfrl_pkg::OP_APPEND) begin
            state_nxt = cfrl_pkg::ST_CRC;
          end else if ({1'b0, in_read_index} >= (cfrl_pkg::INDEX_W+1)'(stored_now)) begin
            state_nxt = cfrl_pkg::ST_FIN;
          end else begin
            state_nxt = cfrl_pkg::ST_ADDR;
          end
        end
      end
      cfrl_pkg::ST_ADDR: state_nxt = cfrl_pkg::ST_SLOT;
      cfrl_pkg::ST_SLOT: state_nxt = cfrl_pkg::ST_RD;
      cfrl_pkg::ST_RD:   state_nxt = cfrl_pkg::ST_LOAD;
      cfrl_pkg::ST_LOAD: state_nxt = cfrl_pkg::ST_CRC;
      cfrl_pkg::ST_CRC: begin
        if (bcnt_r == cfrl_pkg::BCNT_W'(cfrl_pkg::REC_BYTES - 1)) begin
          state_nxt = cfrl_pkg::ST_FIN;
        end
      end
      cfrl_pkg::ST_FIN: begin
        if (fin_go) begin
          state_nxt = cfrl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfrl_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfrl_pkg::ST_IDLE;
      wp_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        total_r <= seq_new;
        if (wp_r == cfrl_pkg::ADDR_W'(cfrl_pkg::LOG_DEPTH - 1)) begin
          wp_r <= '0;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      cfrl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op_r     <= in_operation;
          range_r  <= ({1'b0, in_read_index} >= (cfrl_pkg::INDEX_W+1)'(stored_now));
          idx_r    <= in_read_index[cfrl_pkg::CNT_W-1:0];
          stored_r <= stored_now;
          rec_r.seq <= seq_new;
          rec_r.ts  <= in_timestamp;
          rec_r.css <= {in_source, in_severity, in_event_code};
          rec_r.ca  <= in_context_a;
          rec_r.cb  <= in_context_b;
          rec_r.crc <= '0;
          sh_r      <= {in_context_b, in_context_a, in_source, in_severity,
                        in_event_code, in_timestamp, seq_new};
          crc_r     <= cfrl_pkg::CRC_INIT;
          bcnt_r    <= '0;
        end
      end
      cfrl_pkg::ST_ADDR: begin
        if (oldest_sum >= SUM_W'(cfrl_pkg::LOG_DEPTH)) begin
          oldest_r <= cfrl_pkg::ADDR_W'(oldest_sum - SUM_W'(cfrl_pkg::LOG_DEPTH));
        end else begin
          oldest_r <= cfrl_pkg::ADDR_W'(oldest_sum);
        end
      end
      cfrl_pkg::ST_SLOT: begin
        if (slot_sum >= SUM_W'(cfrl_pkg::LOG_DEPTH)) begin
          slot_r <= cfrl_pkg::ADDR_W'(slot_sum - SUM_W'(cfrl_pkg::LOG_DEPTH));
        end else begin
          slot_r <= cfrl_pkg::ADDR_W'(slot_sum);
        end
      end
      cfrl_pkg::ST_LOAD: begin
        rec_r  <= mem_q_r;
        sh_r   <= {mem_q_r.cb, mem_q_r.ca, mem_q_r.css, mem_q_r.ts, mem_q_r.seq};
        crc_r  <= cfrl_pkg::CRC_INIT;
        bcnt_r <= '0;
      end
      cfrl_pkg::ST_CRC: begin
        crc_r  <= cfrl_pkg::crc_byte(crc_r, sh_r[cfrl_pkg::BYTE_W-1:0]);
        sh_r   <= sh_r >> cfrl_pkg::BYTE_W;
        bcnt_r <= bcnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Record store: one write port at the write pointer, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= mem_wdata;
    end
    if (state_r == cfrl_pkg::ST_RD) begin
      mem_q_r <= mem[slot_r];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_total_r  <= total_new;
      out_stored_r <= cfrl_pkg::STORED_W'(cfrl_pkg::stored_of(total_new));
      out_ts_r     <= '0;
      out_css_r    <= '0;
      out_ca_r     <= '0;
      out_cb_r     <= '0;
      if (op_r == cfrl_pkg::OP_APPEND) begin
        out_status_r <= cfrl_pkg::STAT_OK;
      end else if (range_r) begin
        out_status_r <= cfrl_pkg::STAT_RANGE;
      end else if (crc_final != rec_r.crc) begin
        out_status_r <= cfrl_pkg::STAT_CRC;
      end else begin
        out_status_r <= cfrl_pkg::STAT_OK;
        out_ts_r     <= rec_r.ts;
        out_css_r    <= rec_r.css;
        out_ca_r     <= rec_r.ca;
        out_cb_r     <= rec_r.cb;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_timestamp    = out_ts_r;
  assign out_event_code   = out_css_r[cfrl_pkg::CODE_W-1:0];
  assign out_severity     = out_css_r[cfrl_pkg::CODE_W +: cfrl_pkg::BYTE_W];
  assign out_source       = out_css_r[cfrl_pkg::CODE_W+cfrl_pkg::BYTE_W +: cfrl_pkg::BYTE_W];
  assign out_context_a    = out_ca_r;
  assign out_context_b    = out_cb_r;
  assign out_logged_total = out_total_r;
  assign out_stored_count = out_stored_r;

  // An append that completes bumps the total by exactly one
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> total_r == $past(total_r) + 32'd1)
    else $error("total did not advance on append");

  // The total only moves when an append completes
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_we |=> total_r == $past(total_r))
    else $error("total moved without an append");

  // Reported occupancy never exceeds the ring depth
  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stored_count <= cfrl_pkg::STORED_W'(cfrl_pkg::LOG_DEPTH))
    else $error("stored count beyond depth");

  // Record fields are zero unless a read came back good
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != cfrl_pkg::STAT_OK) |->
      (out_timestamp == '0 && out_context_a == '0 && out_context_b == '0))
    else $error("record fields set on failed read");

endmodule
